FILE: rtl/core/spq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
// Holds the word structs, the status codes and the cell control bundle.
// No dependencies.
package spq_pkg;

  // Fixed dimensions of the queue and of its words
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned OCC_W    = $clog2(CAPACITY + 1);

  // Input word kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  // Input word
  typedef struct packed {
    logic              kind;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  tag;
  } spq_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]        status;
    logic [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]  out_tag;
    logic [OCC_W-1:0]  occupancy;
  } spq_out_t;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } spq_entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t entry;
  } spq_ctrl_t;

endpackage

FILE: rtl/core/stable_priority_queue_top.sv
// Stable sorted priority queue: a chain of entry cells in sorted order.
// Takes input words (insert or remove) and returns one result word for each.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel in_valid_i / in_ready_o / in_data_i carries an insert
//   (priority and tag) or a remove. Output channel out_valid_o / out_ready_i /
//   out_data_o carries one result per input word: status, the removed entry
//   (zero for inserts and refusals) and the occupancy after the word.
//   Inserts go behind every stored entry of lower or equal priority, so
//   lower values leave first and equal priorities leave in arrival order.
//   An insert into a full queue returns ST_FULL, a remove from an empty
//   queue returns ST_EMPTY; neither changes the contents.
// Timing:
//   Every cell updates in the same cycle, so a word is accepted, applied and
//   its result registered together; throughput one word per cycle while the
//   receiver keeps taking results. The single output register sets the rate;
//   the next word is taken in the cycle the current result is taken.
// Reset:
//   rst_ni clears the entry count and the output valid; cell contents are
//   never read before being written. A stalled receiver holds the result and
//   in_ready_o stays low until it is taken.
module stable_priority_queue_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  logic [OCC_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  spq_out_t         out_data_q, out_data_d;

  logic             in_fire;
  logic             is_full, is_empty;
  spq_ctrl_t        ctrl;

  spq_entry_t       cell_entry [CAPACITY];
  logic             cell_keep  [CAPACITY];

  // Accept a word whenever the output register is free or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == OCC_W'(CAPACITY));
  assign is_empty   = (count_q == '0);

  // Broadcast the operation to the chain
  always_comb begin
    ctrl.ins        = in_fire && (in_data_i.kind == KIND_INSERT) && !is_full;
    ctrl.rem        = in_fire && (in_data_i.kind == KIND_REMOVE) && !is_empty;
    ctrl.entry.prio = in_data_i.priority_req;
    ctrl.entry.tag  = in_data_i.tag;
  end

  // Chain of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (count_q > OCC_W'(i)),
      .keep_prev_i ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
      .prev_i      (cell_entry[(i == 0) ? 0 : i - 1]),
      .next_i      (cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
      .keep_o      (cell_keep[i]),
      .entry_o     (cell_entry[i])
    );
  end

  // Advance the count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + OCC_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - OCC_W'(1);
    end
  end

  // Build the result word
  always_comb begin
    out_data_d              = out_data_q;
    out_valid_d             = out_valid_q && !out_ready_i;
    if (in_fire) begin
      out_valid_d             = 1'b1;
      out_data_d.status       = ST_OK;
      out_data_d.out_priority = '0;
      out_data_d.out_tag      = '0;
      out_data_d.occupancy    = count_d;
      if (in_data_i.kind == KIND_INSERT) begin
        if (is_full) begin
          out_data_d.status = ST_FULL;
        end
      end else if (is_empty) begin
        out_data_d.status = ST_EMPTY;
      end else begin
        out_data_d.out_priority = cell_entry[0].prio;
        out_data_d.out_tag      = cell_entry[0].tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Count never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OCC_W'(CAPACITY))
    else $error("entry count above capacity");

  // The two head entries stay in priority order
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= OCC_W'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
    else $error("head entries out of order");

  // A full refusal is reported only when the queue was full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.kind == KIND_INSERT && !is_full)
      |=> (out_data_q.status == ST_OK && count_q == $past(count_q) + OCC_W'(1)))
    else $error("insert into non-full queue not taken");

  // The reported occupancy matches the count after the word
  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_data_q.occupancy == count_q))
    else $error("occupancy does not match entry count");

endmodule

FILE: rtl/core/spq_cell.sv
// One cell of the sorted chain: holds a single entry and decides each cycle
// whether to hold it, take the new entry, or take a neighbour's entry.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  logic               keep_prev_i,
  input  spq_pkg::spq_entry_t prev_i,
  input  spq_pkg::spq_entry_t next_i,
  output logic               keep_o,
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // Keep own entry on insert when it is stored and not above the new priority
  assign keep_o  = valid_i && (entry_q.prio <= ctrl_i.entry.prio);
  assign entry_o = entry_q;

  // Choose the next content: hold, take the new entry, shift back or advance
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        entry_d = keep_prev_i ? ctrl_i.entry : prev_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: bench/stable_priority_queue_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for stable_priority_queue_top: directed rows, then random bursts.
// Predicts untyped result words from its own copy of the sorted entries; depends on spq_pkg.
module stable_priority_queue_top_test;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_WORDS   = 1350;

  // One stimulus row: the word, and its result where it is typed in by hand
  typedef struct {
    spq_in_t  word;
    bit       typed;
    spq_out_t result;
  } row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  spq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  spq_out_t out_data_o;

  spq_entry_t  held_entries[$];
  spq_out_t    pending_results[$];
  row_t        typed_results[$];
  row_t        directed_rows[25];
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int          recv_run     = 0;
  int          recv_stall   = 0;
  int          recv_phase   = 0;
  bit          recv_calm    = 1'b0;
  spq_out_t    predicted;
  spq_out_t    oldest;
  row_t        sent_row;

  stable_priority_queue_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one word to the local copy of the queue and return its result
  function automatic spq_out_t apply_word(input spq_in_t w);
    spq_out_t   r;
    spq_entry_t e;
    int         pos;
    r = '0;
    if (w.kind == KIND_INSERT) begin
      if (held_entries.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // skip every entry of lower or equal priority, so ties keep arrival order
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio <= w.priority_req) pos++;
        e.prio = w.priority_req;
        e.tag  = w.tag;
        held_entries.insert(pos, e);
        r.status = ST_OK;
      end
    end else if (held_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e = held_entries.pop_front();
      r.status       = ST_OK;
      r.out_priority = e.prio;
      r.out_tag      = e.tag;
    end
    r.occupancy = OCC_W'(held_entries.size());
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic row_t make_row(input logic kind, input logic [PRIO_W-1:0] prio,
                                    input logic [TAG_W-1:0] tg, input bit typed,
                                    input spq_status_e st, input logic [PRIO_W-1:0] op,
                                    input logic [TAG_W-1:0] ot, input logic [OCC_W-1:0] occ);
    row_t r;
    r.word.kind           = kind;
    r.word.priority_req   = prio;
    r.word.tag            = tg;
    r.typed               = typed;
    r.result.status       = st;
    r.result.out_priority = op;
    r.result.out_tag      = ot;
    r.result.occupancy    = occ;
    return r;
  endfunction

  // Present one word after an optional gap and hold it until accepted
  task automatic send_word(input row_t r, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_results.push_back(r);
    in_valid_i <= 1'b1;
    in_data_i  <= r.word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: bursts of ready, random stalls, with calm stretches of no stalling
  always @(posedge clk_i) begin
    if (recv_phase == 0) begin
      recv_phase = $urandom_range(200, 600);
      recv_calm  = ($urandom_range(0, 3) == 0);
    end else begin
      recv_phase--;
    end
    if (recv_run > 0) begin
      recv_run--;
      out_ready_i <= 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready_i <= 1'b0;
    end else begin
      recv_run   = $urandom_range(0, 7);
      recv_stall = recv_calm ? 0 : pick_gap();
      out_ready_i <= (recv_stall == 0);
    end
  end

  // Check each result word against the oldest expectation, then predict new words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with no expectation waiting: %h", out_data_o);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_data_o.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_data_o.status);
            mismatches++;
          end
          if (out_data_o.out_priority !== oldest.out_priority) begin
            $error("out_priority: expected %0d, got %0d",
                   oldest.out_priority, out_data_o.out_priority);
            mismatches++;
          end
          if (out_data_o.out_tag !== oldest.out_tag) begin
            $error("out_tag: expected %h, got %h", oldest.out_tag, out_data_o.out_tag);
            mismatches++;
          end
          if (out_data_o.occupancy !== oldest.occupancy) begin
            $error("occupancy: expected %0d, got %0d", oldest.occupancy, out_data_o.occupancy);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted = apply_word(in_data_i);
        sent_row  = typed_results.pop_front();
        pending_results.push_back(sent_row.typed ? sent_row.result : predicted);
      end
    end
  end

  // Watchdog: abort after too many cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int                sent;
    int                burst;
    int                burst_len;
    int                ins_pct;
    int                prio_mode;
    int                base;
    int                gap;
    bit                calm;
    logic [PRIO_W-1:0] prio_pick;
    logic [TAG_W-1:0]  tag_pick;
    row_t              r;

    // empty and single-entry cases, a fill to capacity with ties, refusals, head removes
    directed_rows[0]  = make_row(KIND_REMOVE, 8'h00, 16'h0000, 1, ST_EMPTY, 0, 0, 0);
    directed_rows[1]  = make_row(KIND_INSERT, 8'hFF, 16'hFFFF, 1, ST_OK, 0, 0, 1);
    directed_rows[2]  = make_row(KIND_REMOVE, 8'h00, 16'h0000, 1, ST_OK, 8'hFF, 16'hFFFF, 0);
    directed_rows[3]  = make_row(KIND_REMOVE, 8'hFF, 16'hFFFF, 1, ST_EMPTY, 0, 0, 0);
    directed_rows[4]  = make_row(KIND_INSERT, 8'h00, 16'h0000, 1, ST_OK, 0, 0, 1);
    directed_rows[5]  = make_row(KIND_INSERT, 8'h80, 16'h1234, 0, ST_OK, 0, 0, 0);
    directed_rows[6]  = make_row(KIND_INSERT, 8'h80, 16'h5678, 0, ST_OK, 0, 0, 0);
    directed_rows[7]  = make_row(KIND_INSERT, 8'h80, 16'h9ABC, 0, ST_OK, 0, 0, 0);
    directed_rows[8]  = make_row(KIND_INSERT, 8'h7F, 16'h0001, 0, ST_OK, 0, 0, 0);
    directed_rows[9]  = make_row(KIND_INSERT, 8'h81, 16'h0002, 0, ST_OK, 0, 0, 0);
    directed_rows[10] = make_row(KIND_INSERT, 8'hFF, 16'hFFFF, 0, ST_OK, 0, 0, 0);
    directed_rows[11] = make_row(KIND_INSERT, 8'h00, 16'h0003, 0, ST_OK, 0, 0, 0);
    directed_rows[12] = make_row(KIND_INSERT, 8'hFF, 16'h0004, 0, ST_OK, 0, 0, 0);
    directed_rows[13] = make_row(KIND_INSERT, 8'h01, 16'hAAAA, 0, ST_OK, 0, 0, 0);
    directed_rows[14] = make_row(KIND_INSERT, 8'hFE, 16'h5555, 0, ST_OK, 0, 0, 0);
    directed_rows[15] = make_row(KIND_INSERT, 8'h40, 16'h0F0F, 0, ST_OK, 0, 0, 0);
    directed_rows[16] = make_row(KIND_INSERT, 8'hC0, 16'hF0F0, 0, ST_OK, 0, 0, 0);
    directed_rows[17] = make_row(KIND_INSERT, 8'h80, 16'h0005, 0, ST_OK, 0, 0, 0);
    directed_rows[18] = make_row(KIND_INSERT, 8'h20, 16'h8000, 0, ST_OK, 0, 0, 0);
    directed_rows[19] = make_row(KIND_INSERT, 8'hE0, 16'h7FFF, 0, ST_OK, 0, 0, 0);
    directed_rows[20] = make_row(KIND_INSERT, 8'h10, 16'hDEAD, 1, ST_FULL, 0, 0, 16);
    directed_rows[21] = make_row(KIND_INSERT, 8'h00, 16'hBEEF, 1, ST_FULL, 0, 0, 16);
    directed_rows[22] = make_row(KIND_REMOVE, 8'h00, 16'h0000, 0, ST_OK, 0, 0, 0);
    directed_rows[23] = make_row(KIND_REMOVE, 8'hFF, 16'hFFFF, 0, ST_OK, 0, 0, 0);
    directed_rows[24] = make_row(KIND_REMOVE, 8'h55, 16'hAAAA, 0, ST_OK, 0, 0, 0);

    // hold reset low before releasing it
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_word(directed_rows[i], pick_gap());

    // random bursts: each leans towards filling or draining, with its own priority spread
    sent  = 0;
    burst = 0;
    while (sent < RANDOM_WORDS) begin
      burst_len = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0: ins_pct = 85;
        1: ins_pct = 15;
        2: ins_pct = 50;
        3: ins_pct = 65;
        default: ins_pct = 35;
      endcase
      prio_mode = $urandom_range(0, 3);
      base      = $urandom_range(0, 248);
      calm      = ($urandom_range(0, 3) == 0);

      // now and then let every result come home before going on
      if (burst == 2 || $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end

      for (int n = 0; n < burst_len; n++) begin
        case (prio_mode)
          0: prio_pick = PRIO_W'($urandom_range(0, 255));
          1: prio_pick = PRIO_W'($urandom_range(0, 3));
          2: begin
            case ($urandom_range(0, 3))
              0: prio_pick = 8'h00;
              1: prio_pick = 8'hFF;
              2: prio_pick = 8'h7F;
              default: prio_pick = 8'h80;
            endcase
          end
          default: prio_pick = PRIO_W'(base + $urandom_range(0, 7));
        endcase
        case ($urandom_range(0, 9))
          0: tag_pick = 16'h0000;
          1: tag_pick = 16'hFFFF;
          default: tag_pick = TAG_W'($urandom_range(0, 65535));
        endcase
        r.word.kind         = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
        r.word.priority_req = prio_pick;
        r.word.tag          = tag_pick;
        r.typed             = 1'b0;
        r.result            = '0;
        gap = calm ? 0 : pick_gap();
        send_word(r, gap);
        sent++;
      end
      burst++;
    end

    // drain: wait for every expected word, then keep watching for strays
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_top.sv
bench/stable_priority_queue_top_test.sv
